// File: sv/next_k_combination_engine_assert.svh
// Assertion macros used by the checker of the next-k-combination engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef NEXT_K_COMBINATION_ENGINE_ASSERT_SVH
`define NEXT_K_COMBINATION_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nkc_pkg.sv
// Package for the next-k-combination engine: sizes, codes and sequencer states.
// No dependencies; used by next_k_combination_engine and nkc_checker.
package nkc_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int AW = $clog2(MAX_ELEMENTS);      // element address width
  localparam int CW = $clog2(MAX_ELEMENTS + 1);  // count / bound width
  localparam int DW = 8;                         // element width
  localparam int CFG_IW = 1;                     // config index width
  localparam int CFG_DW = 5;                     // config data width

  // Request operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_ELEMENT_COUNT = 1'd0;
  localparam logic [CFG_IW-1:0] REG_SUBSET_SIZE   = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FWD_RD,
    ST_FWD_CMP,
    ST_BLOCK_CHK,
    ST_EXCH,
    ST_REV_SET,
    ST_REV,
    ST_SWP_RD,
    ST_SWP_WA,
    ST_SWP_WB,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_t;

endpackage

// File: sv/next_k_combination_engine.sv
// Next-k-combination engine: element store, swap/compare sequencer, result register.
// Depends on nkc_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | operation, index, value
//  output  | out_valid/out_stall | position, element, in_subset, advanced, last
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load writes the element store directly from idle. An advance with an empty array
// returns to idle; with an empty or full subset it emits the n results directly,
// else it runs the backward scan and forward search, the partner swap and, when the
// block exchange runs, the exchange and reversal swaps, then emits. The single
// read/compare path and the one write port of the element store set its length.
// Results leave at one per cycle while out_stall is low. rst resets the sequencer
// and output valid, sets the element count to 16 and subset size to 0; the element
// store holds nothing defined until loaded. in_stall is high while an advance runs.
module next_k_combination_engine
  import nkc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [3:0]        index,
  input  logic [DW-1:0]     value,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        position,
  output logic [DW-1:0]     element,
  output logic              in_subset,
  output logic              advanced,
  output logic              last,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // Configuration registers
  logic [CFG_DW-1:0] element_count;
  logic [CFG_DW-1:0] subset_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CFG_DW'(16);
      subset_size   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ELEMENT_COUNT: element_count <= cfg_data;
        REG_SUBSET_SIZE:   subset_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Element store: one write port, two registered read ports
  logic [DW-1:0] elem_mem [MAX_ELEMENTS];
  logic          we;
  logic [AW-1:0] wa, ra, rb;
  logic [DW-1:0] wd, qa, qb;

  always_ff @(posedge clk) begin
    if (we) begin
      elem_mem[wa] <= wd;
    end
    qa <= elem_mem[ra];
    qb <= elem_mem[rb];
  end

  // Sequencer registers
  state_t        state, state_next;
  state_t        ret, ret_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] back, back_next;
  logic [CW-1:0] fwd, fwd_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] mark, mark_next;
  logic [CW-1:0] rlo, rlo_next;
  logic [CW-1:0] rhi, rhi_next;
  logic [CW-1:0] pos, pos_next;
  logic [AW-1:0] sa, sa_next;
  logic [AW-1:0] sb, sb_next;
  logic [1:0]    rph, rph_next;
  logic          adv, adv_next;

  // Output register
  logic          out_valid_next;
  logic [3:0]    position_next;
  logic [DW-1:0] element_next;
  logic          in_subset_next, advanced_next, last_next;

  // Helpers
  logic [CW-1:0] tail;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] n_cap;
  logic [CW-1:0] k_cap;
  logic          in_take;
  logic          out_free;
  logic          gt;

  assign tail     = n - CW'(1);
  assign pos_inc  = pos + CW'(1);
  assign n_cap    = (CW'(element_count) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS)
                                                             : CW'(element_count);
  assign k_cap    = (CW'(subset_size) > n_cap) ? n_cap : CW'(subset_size);
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign gt       = (qa > qb);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n         <= n_next;
    k         <= k_next;
    back      <= back_next;
    fwd       <= fwd_next;
    lo        <= lo_next;
    mark      <= mark_next;
    rlo       <= rlo_next;
    rhi       <= rhi_next;
    pos       <= pos_next;
    sa        <= sa_next;
    sb        <= sb_next;
    rph       <= rph_next;
    adv       <= adv_next;
    position  <= position_next;
    element   <= element_next;
    in_subset <= in_subset_next;
    advanced  <= advanced_next;
    last      <= last_next;
  end

  // Next state, store access and result loading
  always_comb begin
    state_next     = state;
    ret_next       = ret;
    n_next         = n;
    k_next         = k;
    back_next      = back;
    fwd_next       = fwd;
    lo_next        = lo;
    mark_next      = mark;
    rlo_next       = rlo;
    rhi_next       = rhi;
    pos_next       = pos;
    sa_next        = sa;
    sb_next        = sb;
    rph_next       = rph;
    adv_next       = adv;
    position_next  = position;
    element_next   = element;
    in_subset_next = in_subset;
    advanced_next  = advanced;
    last_next      = last;
    out_valid_next = out_valid && out_stall;
    we             = 1'b0;
    wa             = '0;
    wd             = value;
    ra             = '0;
    rb             = '0;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (operation == OP_LOAD) begin
            we = (CW'(index) < CW'(MAX_ELEMENTS));
            wa = AW'(index);
            wd = value;
          end else begin
            n_next     = n_cap;
            k_next     = k_cap;
            state_next = ST_START;
          end
        end
      end

      ST_START: begin
        back_next = k - CW'(1);
        fwd_next  = k;
        lo_next   = '0;
        pos_next  = '0;
        adv_next  = 1'b0;
        if (n == '0) begin
          state_next = ST_IDLE;
        end else if (k == '0 || k == n) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end

      // Backward scan for the last subset entry not above the tail
      ST_SCAN_RD: begin
        ra         = back[AW-1:0];
        rb         = tail[AW-1:0];
        state_next = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (back != '0 && gt) begin
          back_next  = back - CW'(1);
          state_next = ST_SCAN_RD;
        end else if (back == '0 && gt) begin
          adv_next   = 1'b0;
          state_next = ST_BLOCK_CHK;
        end else begin
          adv_next   = 1'b1;
          state_next = ST_FWD_RD;
        end
      end

      // Forward search in the complement for the swap partner
      ST_FWD_RD: begin
        ra         = back[AW-1:0];
        rb         = fwd[AW-1:0];
        state_next = ST_FWD_CMP;
      end

      ST_FWD_CMP: begin
        if (fwd != tail && gt) begin
          fwd_next   = fwd + CW'(1);
          state_next = ST_FWD_RD;
        end else begin
          sa_next    = back[AW-1:0];
          sb_next    = fwd[AW-1:0];
          lo_next    = back + CW'(1);
          fwd_next   = fwd + CW'(1);
          ret_next   = ST_BLOCK_CHK;
          state_next = ST_SWP_RD;
        end
      end

      ST_BLOCK_CHK: begin
        if (lo != k && fwd != n) begin
          mark_next  = fwd;
          back_next  = k;
          state_next = ST_EXCH;
        end else begin
          pos_next   = '0;
          state_next = ST_EMIT_RD;
        end
      end

      // Block exchange between subset tail and complement
      ST_EXCH: begin
        if (back != lo && fwd != n) begin
          sa_next    = AW'(back - CW'(1));
          sb_next    = fwd[AW-1:0];
          back_next  = back - CW'(1);
          fwd_next   = fwd + CW'(1);
          ret_next   = ST_EXCH;
          state_next = ST_SWP_RD;
        end else begin
          rph_next   = 2'd0;
          state_next = ST_REV_SET;
        end
      end

      // Four reversals: [lo,back) [lo,k) [fwd,n) [mark,n)
      ST_REV_SET: begin
        case (rph)
          2'd0:    begin rlo_next = lo;   rhi_next = back; end
          2'd1:    begin rlo_next = lo;   rhi_next = k;    end
          2'd2:    begin rlo_next = fwd;  rhi_next = n;    end
          default: begin rlo_next = mark; rhi_next = n;    end
        endcase
        state_next = ST_REV;
      end

      ST_REV: begin
        if (rlo + CW'(1) < rhi) begin
          sa_next    = rlo[AW-1:0];
          sb_next    = AW'(rhi - CW'(1));
          rlo_next   = rlo + CW'(1);
          rhi_next   = rhi - CW'(1);
          ret_next   = ST_REV;
          state_next = ST_SWP_RD;
        end else if (rph == 2'd3) begin
          pos_next   = '0;
          state_next = ST_EMIT_RD;
        end else begin
          rph_next   = rph + 2'd1;
          state_next = ST_REV_SET;
        end
      end

      // Swap subroutine: read both, write each with the other
      ST_SWP_RD: begin
        ra         = sa;
        rb         = sb;
        state_next = ST_SWP_WA;
      end

      // keep reading sa so qa still holds its old value for the second write
      ST_SWP_WA: begin
        ra         = sa;
        we         = 1'b1;
        wa         = sa;
        wd         = qb;
        state_next = ST_SWP_WB;
      end

      ST_SWP_WB: begin
        we         = 1'b1;
        wa         = sb;
        wd         = qa;
        state_next = ret;
      end

      // Emit every position, one per cycle while the sink takes them
      ST_EMIT_RD: begin
        ra         = pos[AW-1:0];
        state_next = ST_EMIT_PUT;
      end

      ST_EMIT_PUT: begin
        ra = pos[AW-1:0];
        if (out_free) begin
          ra             = pos_inc[AW-1:0];
          out_valid_next = 1'b1;
          position_next  = 4'(pos);
          element_next   = qa;
          in_subset_next = (pos < k);
          advanced_next  = adv;
          last_next      = (pos_inc == n);
          pos_next       = pos_inc;
          if (pos_inc == n) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/nkc_checker.sv
// Port-level checker for the next-k-combination engine, bound to the top level.
// Depends on nkc_pkg and next_k_combination_engine_assert.svh.
`include "next_k_combination_engine_assert.svh"

module nkc_checker
  import nkc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          operation,
  input logic          out_valid,
  input logic          out_stall,
  input logic [3:0]    position,
  input logic [DW-1:0] element,
  input logic          last
);

  logic adv_take;
  logic out_take;

  assign adv_take = in_valid && !in_stall && (operation == OP_ADVANCE);
  assign out_take = out_valid && !out_stall;

  // An advance request always occupies the block on the following cycle
  `NKC_ASSERT_NEXT(a_busy_after_advance, adv_take, in_stall, "not busy after advance")

  // A held result keeps its position and element
  `NKC_ASSERT_NEXT(a_result_holds, out_valid && out_stall, $stable(position) && $stable(element), "held result changed")

  // Results of one arrangement follow back to back with rising positions
  `NKC_ASSERT_NEXT(a_next_position, out_take && !last, out_valid && (position == $past(position) + 4'd1), "arrangement gap or position skip")

  // No new request is taken while an arrangement is still being emitted
  `NKC_ASSERT_NOW(a_busy_mid_emit, out_valid && !last, in_stall, "request taken mid-arrangement")

endmodule

bind next_k_combination_engine nkc_checker u_nkc_checker (.*);
